// File: design/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

  localparam int RPM_W      = 24;
  localparam int MIN_W      = 20;
  localparam int TMO_W      = 24;
  localparam int PPR_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int IVL_W      = 32;            // widest interval that can give a speed
  localparam int NUM_W      = 31;            // 960000000 << 1 fits in 31 bits
  localparam int DEN_W      = IVL_W + PPR_W; // interval times pulses per rev
  localparam int CNT_W      = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] RPM_X16_NUM = 31'd960000000;
  localparam logic [RPM_W-1:0] SPEED_MAX   = '1;

  localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = 20'd10000;
  localparam logic [TMO_W-1:0] TIMEOUT_RST      = 24'd1000000;
  localparam logic [PPR_W-1:0] PPR_RST          = 5'd1;

  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_POLL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_TIMEOUT      = 2'd1,
    CFG_PPR          = 2'd2,
    CFG_DOUBLE_RATE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [MIN_W-1:0] min_interval_us;
    logic [TMO_W-1:0] timeout_us;
    logic [PPR_W-1:0] ppr;
    logic             double_rate;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: design/pulse_period_tachometer.sv
`default_nettype none

// Tachometer from pulse timestamps. Each beat on the input carries func (0 = sensor
// edge, 1 = poll) and a microsecond time; each gives exactly one result beat with the
// current speed in sixteenths of RPM and a stale flag. Edges closer than
// min_interval_us to the last kept edge are dropped; a poll turns the latest kept
// interval into a speed, and the speed reads zero once timeout_us passes without a
// fresh one. A poll that converts an interval takes its speed from the 31-step
// bit-serial divider before the result is offered; every other item skips the
// divider. One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Write configuration only while the block
// is idle.
module pulse_period_tachometer #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [31:0]                    in_time_us,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ppt_pkg::RPM_W-1:0]           out_rpm_x16,
  output logic                                out_stale,
  input  wire logic                           cfg_we,
  input  wire logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ppt_pkg::*;

  localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic                 func_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] last_edge_r;
  logic                 has_edge_r;
  logic [TIME_BITS-1:0] held_r;
  logic                 pending_r;
  logic [TIME_BITS-1:0] last_upd_r;
  logic [RPM_W-1:0]     speed_r;
  logic                 stale_r;
  logic [TIME_BITS-1:0] edge_gap_r;
  logic [TIME_BITS-1:0] upd_gap_r;
  logic [DEN_W-1:0]     den_r;
  logic                 out_valid_r;
  logic [RPM_W-1:0]     out_rpm_r;
  logic                 out_stale_r;

  logic [63:0]      held_ext;
  logic             huge;
  logic             fresh;
  logic             edge_keep;
  logic             upd_stale;
  logic [PPR_W-1:0] ppr_eff;
  logic [DEN_W-1:0] den_nxt;
  logic             load_out;
  logic             div_start;
  logic             div_done;
  logic [RPM_W-1:0] div_quot;

  ppt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dbl   (cfg.double_rate),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    held_ext  = 64'(held_r);
    huge      = |held_ext[63:IVL_W];
    fresh     = pending_r && (held_r != '0);
    edge_keep = CMP_W'(edge_gap_r) >= CMP_W'(cfg.min_interval_us);
    upd_stale = CMP_W'(upd_gap_r) > CMP_W'(cfg.timeout_us);
    ppr_eff   = (cfg.ppr == '0) ? PPR_W'(1) : cfg.ppr;
    den_nxt   = {{PPR_W{1'b0}}, held_ext[IVL_W-1:0]} * {{IVL_W{1'b0}}, ppr_eff};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_GAP;
      ST_GAP:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (func_r == FUNC_POLL && fresh && !huge) state_nxt = ST_MUL;
        else                                       state_nxt = ST_DONE;
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    div_start = (state_r == ST_MUL);
    load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_edge_r <= '0;
      has_edge_r  <= 1'b0;
      held_r      <= '0;
      pending_r   <= 1'b0;
      last_upd_r  <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (load_out)                       out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_EVAL: begin
          if (func_r == FUNC_PULSE) begin
            if (!has_edge_r) begin
              last_edge_r <= now_r;
              has_edge_r  <= 1'b1;
            end else if (edge_keep) begin
              held_r      <= edge_gap_r;
              pending_r   <= 1'b1;
              last_edge_r <= now_r;
            end
          end else begin
            pending_r <= 1'b0;
            if (fresh) begin
              last_upd_r <= now_r;
              if (huge) speed_r <= '0;
            end else if (upd_stale) begin
              speed_r <= '0;
            end
          end
        end
        ST_DIV: if (div_done) speed_r <= div_quot;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      func_r <= in_func;
      now_r  <= TIME_BITS'(in_time_us);
    end
    if (state_r == ST_GAP) begin
      edge_gap_r <= now_r - last_edge_r;
      upd_gap_r  <= now_r - last_upd_r;
    end
    if (state_r == ST_EVAL) begin
      // a fresh speed was just stamped at this time, so it cannot be stale
      stale_r <= (func_r == FUNC_POLL && fresh) ? 1'b0 : upd_stale;
    end
    if (state_r == ST_MUL) den_r <= den_nxt;
    if (load_out) begin
      out_rpm_r   <= speed_r;
      out_stale_r <= stale_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rpm_x16 = out_rpm_r;
  assign out_stale   = out_stale_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_load_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid)
    else $error("result loaded but no output beat offered");

  a_pending_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> has_edge_r)
    else $error("interval pending without a recorded edge");

  a_div_starts_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == ST_DIV && !div_start)
    else $error("divider start not followed by the divide phase");

endmodule

`default_nettype wire

// File: design/ppt_cfg.sv
`default_nettype none

module ppt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ppt_pkg::cfg_t                       cfg
);
  import ppt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_interval_us <= MIN_INTERVAL_RST;
      cfg_r.timeout_us      <= TIMEOUT_RST;
      cfg_r.ppr             <= PPR_RST;
      cfg_r.double_rate     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_INTERVAL: cfg_r.min_interval_us <= cfg_wdata[MIN_W-1:0];
        CFG_TIMEOUT:      cfg_r.timeout_us      <= cfg_wdata[TMO_W-1:0];
        CFG_PPR:          cfg_r.ppr             <= cfg_wdata[PPR_W-1:0];
        CFG_DOUBLE_RATE:  cfg_r.double_rate     <= cfg_wdata[0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/ppt_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module ppt_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      dbl,
  input  wire logic [ppt_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic [ppt_pkg::RPM_W-1:0]      quot
);
  import ppt_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, den};
    ge      = ~diff[DEN_W+1];
    rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dbl ? {RPM_X16_NUM[NUM_W-2:0], 1'b0} : RPM_X16_NUM;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = (|quo_r[NUM_W-1:RPM_W]) ? SPEED_MAX : quo_r[RPM_W-1:0];

endmodule

`default_nettype wire
